/* src/mssp_pkg.sv */
// Shared types and codes for the multi-stack shared-pool block.
// No dependencies; imported by multi_stack_shared_pool and the testbench.
`default_nettype none

package mssp_pkg;

    // Payload widths fixed by the request format
    localparam int DATA_W = 32;
    localparam int SID_W  = 2;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [SID_W-1:0]         sid_t;
    typedef logic [1:0]               status_t;
    typedef logic                     req_t;

    // Request kinds
    localparam req_t REQ_PUSH = 1'b0;
    localparam req_t REQ_POP  = 1'b1;

    // Result status codes
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_OVERFLOW  = 2'd1;
    localparam status_t ST_UNDERFLOW = 2'd2;

    // Value returned by a pop from an empty stack
    localparam data_t UNDERFLOW_VALUE = 32'sh7FFF_FFFF;

endpackage

`default_nettype wire

/* src/multi_stack_shared_pool.sv */
// Several LIFO stacks sharing one linked pool of entries with a free list.
// Depends on mssp_pkg (types, request and status codes).
//
//  channel | signals                              | dir | meaning
//  --------+--------------------------------------+-----+---------------------------
//  in      | in_valid/in_ready, req_type,         | in  | push or pop request
//          | stack_id, push_value                 |     |
//  out     | out_valid/out_ready, pop_value,      | out | one result per request
//          | status                               |     |
//
// A push or an underflowing pop is answered from the execute state; any other pop also
// passes through the pop state, having read the stack head and then the entry it names
// through the one read port of each memory. The next request is taken back in idle.
// Reset is immediate: a fill mark stands for the link chain of never-used entries
// and stack heads carry valid bits, so no clearing pass is needed.
// A waiting result holds in the output register; the next request is taken while
// it waits, and the block holds its final step until the slot frees.
`default_nettype none

module multi_stack_shared_pool #(
    parameter int NUM_STACKS = 4,
    parameter int POOL_DEPTH = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire mssp_pkg::req_t   req_type,
    input  wire mssp_pkg::sid_t   stack_id,
    input  wire mssp_pkg::data_t  push_value,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output mssp_pkg::data_t       pop_value,
    output mssp_pkg::status_t     status
);

    import mssp_pkg::*;

    // Pool index with room for the null code, plain pool address, stack address
    localparam int IW      = $clog2(POOL_DEPTH + 1);
    localparam int PW      = $clog2(POOL_DEPTH);
    localparam int SW      = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int PWORD_W = DATA_W + IW;

    localparam logic [IW-1:0] NULL_IDX = IW'(POOL_DEPTH);

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;

    // Memories: pool words {value, link} and stack heads
    logic [PWORD_W-1:0] pool_mem [POOL_DEPTH];
    logic [IW-1:0]      head_mem [NUM_STACKS];

    logic [PWORD_W-1:0] pool_rd_reg;
    logic [IW-1:0]      head_rd_reg;

    logic               pool_we;
    logic               pool_re;
    logic [PW-1:0]      pool_waddr;
    logic [PW-1:0]      pool_raddr;
    logic [PWORD_W-1:0] pool_wdata;
    logic               head_we;
    logic               head_re;
    logic [IW-1:0]      head_wdata;

    // Control state
    logic [1:0]            state_reg, state_next;
    logic [IW-1:0]         free_head_reg, free_head_next;
    logic [IW-1:0]         hwm_reg, hwm_next;
    logic [NUM_STACKS-1:0] head_vld_reg, head_vld_next;
    logic                  out_valid_reg, out_valid_next;

    // Request and result payload
    req_t      req_type_reg;
    logic      sid_ok_reg;
    logic [SW-1:0] sid_addr_reg;
    data_t     push_value_reg;
    data_t     pop_value_reg, pop_value_next;
    status_t   status_reg, status_next;

    // Derived signals
    logic [31:0]   sid_wide;
    logic          sid_in_ok;
    logic [SW-1:0] sid_in_addr;
    logic          in_fire;
    logic          out_free;
    logic [PW-1:0] free_addr;
    logic [IW-1:0] head_cur;
    logic          push_ok;
    logic          pop_ok;
    logic          fresh;
    logic [IW-1:0] free_after_push;
    data_t         pool_value;
    logic [IW-1:0] pool_link;

    // Decode the incoming stack id
    assign sid_wide    = 32'(stack_id);
    assign sid_in_ok   = sid_wide < 32'(NUM_STACKS);
    assign sid_in_addr = sid_in_ok ? sid_wide[SW-1:0] : '0;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Current free head as a pool address; null maps to entry zero
    assign free_addr = (free_head_reg < NULL_IDX) ? free_head_reg[PW-1:0] : '0;

    // Stack head of the held request; a never-written head reads as null
    assign head_cur = (sid_ok_reg && head_vld_reg[sid_addr_reg]) ? head_rd_reg : NULL_IDX;

    assign push_ok = sid_ok_reg && (free_head_reg < NULL_IDX);
    assign pop_ok  = head_cur < NULL_IDX;

    // Entries at or past the fill mark were never linked: their link is index + 1
    assign fresh           = (free_head_reg == hwm_reg);
    assign pool_link       = pool_rd_reg[IW-1:0];
    assign pool_value      = pool_rd_reg[PWORD_W-1:IW];
    assign free_after_push = fresh ? (free_head_reg + IW'(1)) : pool_link;

    // Sequence one request through read, modify and write back
    always_comb
    begin
        state_next     = state_reg;
        free_head_next = free_head_reg;
        hwm_next       = hwm_reg;
        head_vld_next  = head_vld_reg;
        out_valid_next = out_valid_reg && !out_ready;
        pop_value_next = pop_value_reg;
        status_next    = status_reg;
        pool_we        = 1'b0;
        pool_re        = 1'b0;
        pool_waddr     = free_addr;
        pool_raddr     = free_addr;
        pool_wdata     = {push_value_reg, head_cur};
        head_we        = 1'b0;
        head_re        = 1'b0;
        head_wdata     = free_head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                // Read the stack head and the free entry's link together
                if (in_fire)
                begin
                    head_re    = 1'b1;
                    pool_re    = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (req_type_reg == REQ_PUSH)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        pop_value_next = '0;
                        state_next     = S_IDLE;
                        if (push_ok)
                        begin
                            // Link the free entry on top of the stack
                            pool_we        = 1'b1;
                            pool_waddr     = free_addr;
                            pool_wdata     = {push_value_reg, head_cur};
                            head_we        = 1'b1;
                            head_wdata     = free_head_reg;
                            head_vld_next[sid_addr_reg] = 1'b1;
                            free_head_next = free_after_push;
                            if (fresh)
                            begin
                                hwm_next = hwm_reg + IW'(1);
                            end
                            status_next = ST_OK;
                        end
                        else
                        begin
                            status_next = ST_OVERFLOW;
                        end
                    end
                end
                else if (!pop_ok)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        pop_value_next = UNDERFLOW_VALUE;
                        status_next    = ST_UNDERFLOW;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    // Fetch the top entry's value and link
                    pool_re    = 1'b1;
                    pool_raddr = head_cur[PW-1:0];
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                if (out_free)
                begin
                    // Unlink the top entry and return it to the free list
                    head_we        = 1'b1;
                    head_wdata     = pool_link;
                    pool_we        = 1'b1;
                    pool_waddr     = head_cur[PW-1:0];
                    pool_wdata     = {pool_value, free_head_reg};
                    free_head_next = head_cur;
                    out_valid_next = 1'b1;
                    pop_value_next = pool_value;
                    status_next    = ST_OK;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Pool memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (pool_we)
        begin
            pool_mem[pool_waddr] <= pool_wdata;
        end
        if (pool_re)
        begin
            pool_rd_reg <= pool_mem[pool_raddr];
        end
    end

    // Stack head memory
    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[sid_addr_reg] <= head_wdata;
        end
        if (head_re)
        begin
            head_rd_reg <= head_mem[sid_in_addr];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            hwm_reg       <= '0;
            head_vld_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            hwm_reg       <= hwm_next;
            head_vld_reg  <= head_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the request and hold the result
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_type_reg   <= req_type;
            sid_ok_reg     <= sid_in_ok;
            sid_addr_reg   <= sid_in_addr;
            push_value_reg <= push_value;
        end
        pop_value_reg <= pop_value_next;
        status_reg    <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign pop_value = pop_value_reg;
    assign status    = status_reg;

    // Recycled free entries always lie below the fill mark
    a_free_below_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (free_head_reg != hwm_reg && free_head_reg != NULL_IDX) |-> free_head_reg < hwm_reg)
        else $error("free head past fill mark without being fresh");

    // Fill mark never passes the pool size
    a_mark_range: assert property (@(posedge clk) disable iff (!rst_n)
        hwm_reg <= NULL_IDX && free_head_reg <= NULL_IDX)
        else $error("fill mark or free head out of range");

    // A pool write ends the request and frees the input side
    a_write_ends: assert property (@(posedge clk) disable iff (!rst_n)
        pool_we |=> (state_reg == S_IDLE && out_valid_reg))
        else $error("pool write did not complete the request");

    // Pool read and write never share a cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(pool_we && pool_re))
        else $error("pool read and write in the same cycle");

endmodule

`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for multi_stack_shared_pool: push/pop requests
// against a cycle-free stack-pool predictor. Depends on mssp_pkg and the block.
`timescale 1ns / 1ps

module tb;

    import mssp_pkg::*;

    localparam int NUM_STACKS   = 4;
    localparam int POOL_DEPTH   = 16;
    localparam int IDX_W        = $clog2(POOL_DEPTH + 1);
    localparam int NULL_ENTRY   = POOL_DEPTH;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        data_t   value;
        status_t st;
    } stack_result_t;

    logic    clk        = 1'b0;
    logic    rst_n      = 1'b0;
    logic    in_valid   = 1'b0;
    logic    in_ready;
    req_t    req_type   = REQ_PUSH;
    sid_t    stack_id   = '0;
    data_t   push_value = '0;
    logic    out_valid;
    logic    out_ready  = 1'b0;
    data_t   pop_value;
    status_t status;

    // Predictor state: pool links, stack tops, free-list head, stored values
    logic [IDX_W-1:0] next_link [POOL_DEPTH];
    logic [IDX_W-1:0] top_of    [NUM_STACKS];
    logic [IDX_W-1:0] free_top;
    data_t            pool_value[POOL_DEPTH];

    stack_result_t pending_results[$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int tx_idle_pct    = 0;
    int rx_idle_pct    = 0;
    int rx_hold_cycles = 0;

    multi_stack_shared_pool #(
        .NUM_STACKS (NUM_STACKS),
        .POOL_DEPTH (POOL_DEPTH)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .stack_id   (stack_id),
        .push_value (push_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pop_value  (pop_value),
        .status     (status)
    );

    always #1 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Drive result-side backpressure; a hold-off overrides random stalls
    always @(posedge clk)
    begin
        if (rx_hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            rx_hold_cycles--;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("[%0t] mismatch: %s expected %h got %h", $time, what, want, got);
        mismatch_count++;
    endtask

    // Check each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        stack_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result, status", '0, 32'(status));
            end
            else
            begin
                want = pending_results.pop_front();
                if (pop_value !== want.value)
                    report_mismatch("pop_value", want.value, pop_value);
                if (status !== want.st)
                    report_mismatch("status", 32'(want.st), 32'(status));
            end
        end
    end

    task automatic reset_pool_model();
        for (int i = 0; i < POOL_DEPTH; i++)
        begin
            next_link[i]  = IDX_W'(i + 1);
            pool_value[i] = '0;
        end
        for (int s = 0; s < NUM_STACKS; s++)
            top_of[s] = IDX_W'(NULL_ENTRY);
        free_top = '0;
    endtask

    // Apply one request to the predictor and queue the result it produces
    task automatic apply_stack_request(input req_t kind, input sid_t sid,
                                       input data_t value);
        stack_result_t    r;
        logic [IDX_W-1:0] e;
        r.value = '0;
        r.st    = ST_OK;
        if (kind == REQ_PUSH)
        begin
            e = free_top;
            if (int'(sid) >= NUM_STACKS || e >= POOL_DEPTH)
            begin
                r.st = ST_OVERFLOW;
            end
            else
            begin
                free_top      = next_link[e];
                next_link[e]  = top_of[sid];
                top_of[sid]   = e;
                pool_value[e] = value;
            end
        end
        else
        begin
            e = (int'(sid) < NUM_STACKS) ? top_of[sid] : IDX_W'(NULL_ENTRY);
            if (e >= POOL_DEPTH)
            begin
                r.st    = ST_UNDERFLOW;
                r.value = UNDERFLOW_VALUE;
            end
            else
            begin
                top_of[sid]  = next_link[e];
                next_link[e] = free_top;
                free_top     = e;
                r.value      = pool_value[e];
            end
        end
        pending_results.push_back(r);
    endtask

    // Offer one request, idling first at random, and wait for acceptance
    task automatic send_request(input req_t kind, input sid_t sid, input data_t value);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= kind;
        stack_id   <= sid;
        push_value <= value;
        do @(posedge clk); while (!in_ready);
        apply_stack_request(kind, sid, value);
    endtask

    // Drop valid and hold until every expected result is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic data_t pick_value();
        case ($urandom_range(15))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return '0;
            3: return -1;
            default: return data_t'($urandom);
        endcase
    endfunction

    // Underflow on every empty stack, fill the pool with extremes, overflow, pop back
    task automatic test_directed();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int s = 0; s < NUM_STACKS; s++)
            send_request(REQ_POP, sid_t'(s), data_t'($urandom));
        for (int i = 0; i < POOL_DEPTH; i++)
        begin
            case (i)
                0:       send_request(REQ_PUSH, sid_t'(i), 32'sh8000_0000);
                1:       send_request(REQ_PUSH, sid_t'(i), 32'sh7FFF_FFFF);
                2:       send_request(REQ_PUSH, sid_t'(i), '0);
                3:       send_request(REQ_PUSH, sid_t'(i), -1);
                default: send_request(REQ_PUSH, sid_t'(i), data_t'($urandom));
            endcase
        end
        send_request(REQ_PUSH, sid_t'(2), 32'sh1234_5678);
        send_request(REQ_POP, sid_t'(0), '0);
        send_request(REQ_POP, sid_t'(0), '0);
        send_request(REQ_POP, sid_t'(3), '0);
        wait_drained();
    endtask

    // Alternate push-heavy and pop-heavy bursts so the pool fills and empties
    task automatic test_random_traffic(input int count, input int tx_pct, input int rx_pct);
        int   push_bias;
        req_t kind;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int i = 0; i < count; i++)
        begin
            push_bias = ((i / 48) % 2 == 0) ? 75 : 25;
            kind = ($urandom_range(99) < push_bias) ? REQ_PUSH : REQ_POP;
            send_request(kind, sid_t'($urandom_range(NUM_STACKS - 1)), pick_value());
        end
        wait_drained();
    endtask

    // Stall the result side for a long stretch while requests keep coming
    task automatic test_receiver_holdoff();
        req_t kind;
        tx_idle_pct    = 0;
        rx_idle_pct    = 0;
        rx_hold_cycles = 300;
        for (int i = 0; i < 40; i++)
        begin
            kind = ($urandom_range(1) == 0) ? REQ_PUSH : REQ_POP;
            send_request(kind, sid_t'($urandom_range(NUM_STACKS - 1)), pick_value());
        end
        wait_drained();
    endtask

    // Pause the request side until all results are back, then resume
    task automatic test_sender_pause();
        tx_idle_pct = 10;
        rx_idle_pct = 30;
        for (int i = 0; i < 20; i++)
            send_request(REQ_PUSH, sid_t'($urandom_range(NUM_STACKS - 1)), pick_value());
        wait_drained();
        for (int i = 0; i < 20; i++)
            send_request(REQ_POP, sid_t'($urandom_range(NUM_STACKS - 1)), '0);
        wait_drained();
    endtask

    initial
    begin
        reset_pool_model();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic(300, 22, 57);
        test_random_traffic(300, 57, 22);
        test_random_traffic(300, 0, 0);
        test_receiver_holdoff();
        test_sender_pause();

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
